// File: design/ggr_pkg.sv
package ggr_pkg;

	// Volume geometry
	localparam int unsigned MAX_X     = 32;
	localparam int unsigned MAX_Y     = 32;
	localparam int unsigned MAX_Z     = 32;
	localparam int unsigned VOL_WORDS = MAX_X * MAX_Y * MAX_Z;
	localparam int unsigned ADDR_W    = $clog2(VOL_WORDS);

	// Fixed field widths
	localparam int unsigned COORD_W = 5;
	localparam int unsigned SIZE_W  = 6;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned STEP_W  = 3;

	// Item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SIZE_X      = 2'd0,
		REG_SIZE_Y      = 2'd1,
		REG_SIZE_Z      = 2'd2,
		REG_INV_SPACING = 2'd3
	} cfg_reg_t;

	// Read sequence of one query: centre, then low and high neighbor per axis
	typedef enum logic [STEP_W-1:0] {
		STEP_CENTRE = 3'd0,
		STEP_X_LO   = 3'd1,
		STEP_X_HI   = 3'd2,
		STEP_Y_LO   = 3'd3,
		STEP_Y_HI   = 3'd4,
		STEP_Z_LO   = 3'd5,
		STEP_Z_HI   = 3'd6
	} step_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_DRAIN = 2'd2,
		ST_HOLD  = 2'd3
	} ggr_state_t;

	// One difference going into the scaler
	typedef struct packed {
		logic                     vld;
		axis_t                    axis;
		logic                     half;
		logic signed [DATA_W:0]   diff;
	} ggr_diff_t;

	// One scaled gradient component
	typedef struct packed {
		logic                     vld;
		axis_t                    axis;
		logic                     sat;
		logic signed [DATA_W-1:0] grad;
	} ggr_res_t;

	// Size register clipped to the volume maximum
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
	                                               input int unsigned m);
		logic [SIZE_W-1:0] res;
		res = r;
		if (int'(r) > int'(m)) begin
			res = SIZE_W'(m);
		end
		return res;
	endfunction

	// Linear voxel address, x fastest
	function automatic logic [ADDR_W-1:0] vox_addr(input logic [COORD_W-1:0] x,
	                                               input logic [COORD_W-1:0] y,
	                                               input logic [COORD_W-1:0] z);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(z) * ADDR_W'(MAX_X * MAX_Y) + ADDR_W'(y) * ADDR_W'(MAX_X)
			+ ADDR_W'(x);
		return a;
	endfunction

endpackage

// File: design/ggr_ram.sv
module ggr_ram #(
	parameter int unsigned DEPTH  = 32768,
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ggr_scale.sv
module ggr_scale
	import ggr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DATA_W-1:0]   inv_spacing,
	input  ggr_diff_t           diff_i,
	output ggr_res_t            res_o
);

	// s1: magnitude and sign
	logic                vld_s1;
	axis_t               axis_s1;
	logic                half_s1;
	logic                neg_s1;
	logic [DATA_W-1:0]   mag_s1;
	// s2: product
	logic                vld_s2;
	axis_t               axis_s2;
	logic                half_s2;
	logic                neg_s2;
	logic [2*DATA_W-1:0] prod_s2;
	// s3: rounded magnitude
	logic                vld_s3;
	axis_t               axis_s3;
	logic                neg_s3;
	logic [48:0]         rnd_s3;
	// s4: result
	logic                vld_s4;
	axis_t               axis_s4;
	logic                sat_s4;
	logic [DATA_W-1:0]   grad_s4;

	logic [DATA_W:0]     abs_c;
	logic [47:0]         shr_c;
	logic                rbit_c;
	logic                sat_c;
	logic [DATA_W-1:0]   grad_c;

	always_comb begin
		abs_c = diff_i.diff[DATA_W] ? (~diff_i.diff + 1'b1) : diff_i.diff;
	end

	// Shift by 17 for a central difference, 16 at a face; round half away from zero
	always_comb begin
		shr_c  = half_s2 ? {1'b0, prod_s2[63:17]} : prod_s2[63:16];
		rbit_c = half_s2 ? prod_s2[16] : prod_s2[15];
	end

	// Saturate to 32 bits and restore the sign
	always_comb begin
		if (neg_s3) begin
			sat_c  = (|rnd_s3[48:32]) || (rnd_s3[31] && (|rnd_s3[30:0]));
			grad_c = sat_c ? 32'h8000_0000 : (32'd0 - rnd_s3[31:0]);
		end else begin
			sat_c  = |rnd_s3[48:31];
			grad_c = sat_c ? 32'h7FFF_FFFF : rnd_s3[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= diff_i.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		axis_s1 <= diff_i.axis;
		half_s1 <= diff_i.half;
		neg_s1  <= diff_i.diff[DATA_W];
		mag_s1  <= abs_c[DATA_W-1:0];

		axis_s2 <= axis_s1;
		half_s2 <= half_s1;
		neg_s2  <= neg_s1;
		prod_s2 <= mag_s1 * inv_spacing;

		axis_s3 <= axis_s2;
		neg_s3  <= neg_s2;
		rnd_s3  <= {1'b0, shr_c} + 49'(rbit_c);

		axis_s4 <= axis_s3;
		sat_s4  <= sat_c;
		grad_s4 <= grad_c;
	end

	always_comb begin
		res_o.vld  = vld_s4;
		res_o.axis = axis_s4;
		res_o.sat  = sat_s4;
		res_o.grad = grad_s4;
	end

endmodule

// File: design/grid_gradient_3d.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------
// in       | to block  | in_valid / in_stall  | cmd, coord_x/y/z, voxel_value
// out      | from block| out_valid / out_stall| grad_x/y/z, is_query, out_of_range,
//          |           |                      | saturated
// cfg      | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write, or a query outside the configured size, gives its result in the cycle after accept.
// An in-range query reads seven words from the single-port volume RAM, one per cycle, then
// runs three differences through one 4-stage multiply/round unit.
// One item is in work at a time; an in-range query may be accepted while the last result is stalled.
// Reset sets the size and spacing registers; the volume RAM is not cleared.
module grid_gradient_3d
	import ggr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [COORD_W-1:0]        coord_x,
	input  logic [COORD_W-1:0]        coord_y,
	input  logic [COORD_W-1:0]        coord_z,
	input  logic signed [DATA_W-1:0]  voxel_value,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  grad_x,
	output logic signed [DATA_W-1:0]  grad_y,
	output logic signed [DATA_W-1:0]  grad_z,
	output logic                      is_query,
	output logic                      out_of_range,
	output logic                      saturated,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [DATA_W-1:0]         cfg_data
);

	// Configuration
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [DATA_W-1:0] inv_q;

	// Control
	ggr_state_t        state_q, state_d;
	logic [STEP_W-1:0] k_q;
	logic              rd_vld_s1;
	logic [STEP_W-1:0] rd_k_s1;

	// Query item
	logic [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [2:0]         has_lo_q, has_hi_q;

	// Datapath
	logic signed [DATA_W-1:0] centre_q, lo_q;
	ggr_diff_t                diff_q;
	ggr_res_t                 res;
	logic signed [DATA_W-1:0] gx_q, gy_q, gz_q;
	logic                     sat_q;

	// Output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] ogx_q, ogy_q, ogz_q;
	logic                     oq_q, oor_q, osat_q;

	// RAM port
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_addr, rd_addr;
	logic [DATA_W-1:0] ram_rdata;

	// Input decode
	logic [SIZE_W-1:0] nx, ny, nz;
	logic              oor_in, deep_in, out_free, accept;
	logic [2:0]        has_lo_in, has_hi_in;

	// Output load
	logic                     out_load;
	logic signed [DATA_W-1:0] ld_gx, ld_gy, ld_gz;
	logic                     ld_q, ld_oor, ld_sat;

	logic                     z_done;
	logic signed [DATA_W-1:0] hi_c, lo_c;

	always_comb begin
		nx        = eff_size(size_x_q, MAX_X);
		ny        = eff_size(size_y_q, MAX_Y);
		nz        = eff_size(size_z_q, MAX_Z);
		oor_in    = ({1'b0, coord_x} >= nx) || ({1'b0, coord_y} >= ny)
			|| ({1'b0, coord_z} >= nz);
		deep_in   = (cmd == CMD_QUERY) && !oor_in;
		has_lo_in = {coord_z != '0, coord_y != '0, coord_x != '0};
		has_hi_in = {({1'b0, coord_z} + 1'b1) < nz, ({1'b0, coord_y} + 1'b1) < ny,
			({1'b0, coord_x} + 1'b1) < nx};
		out_free  = !out_valid_q || !out_stall;
	end

	// A result that is ready at once needs the output register free
	assign in_stall  = (state_q != ST_IDLE) || (!out_free && !deep_in);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign z_done    = res.vld && (res.axis == AXIS_Z);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(32);
			size_y_q <= SIZE_W'(32);
			size_z_q <= SIZE_W'(32);
			inv_q    <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SIZE_X:      size_x_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:      size_y_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:      size_z_q <= cfg_data[SIZE_W-1:0];
				REG_INV_SPACING: inv_q    <= cfg_data;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && deep_in) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == STEP_W'(STEP_Z_HI)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (z_done) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// Read address for the current step; wrapped neighbors are never used
	always_comb begin
		unique case (step_t'(k_q))
			STEP_CENTRE: rd_addr = vox_addr(cx_q, cy_q, cz_q);
			STEP_X_LO:   rd_addr = vox_addr(cx_q - 1'b1, cy_q, cz_q);
			STEP_X_HI:   rd_addr = vox_addr(cx_q + 1'b1, cy_q, cz_q);
			STEP_Y_LO:   rd_addr = vox_addr(cx_q, cy_q - 1'b1, cz_q);
			STEP_Y_HI:   rd_addr = vox_addr(cx_q, cy_q + 1'b1, cz_q);
			STEP_Z_LO:   rd_addr = vox_addr(cx_q, cy_q, cz_q - 1'b1);
			STEP_Z_HI:   rd_addr = vox_addr(cx_q, cy_q, cz_q + 1'b1);
			default:     rd_addr = vox_addr(cx_q, cy_q, cz_q);
		endcase
	end

	// State outputs: RAM port and output register load
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = rd_addr;
		out_load = 1'b0;
		ld_gx    = '0;
		ld_gy    = '0;
		ld_gz    = '0;
		ld_q     = cmd;
		ld_oor   = oor_in;
		ld_sat   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_we   = accept && (cmd == CMD_WRITE) && !oor_in;
				ram_addr = vox_addr(coord_x, coord_y, coord_z);
				out_load = accept && !deep_in;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_DRAIN: begin
				out_load = z_done && out_free;
				ld_gx    = gx_q;
				ld_gy    = gy_q;
				ld_gz    = res.grad;
				ld_q     = 1'b1;
				ld_oor   = 1'b0;
				ld_sat   = sat_q || res.sat;
			end
			ST_HOLD: begin
				out_load = out_free;
				ld_gx    = gx_q;
				ld_gy    = gy_q;
				ld_gz    = gz_q;
				ld_q     = 1'b1;
				ld_oor   = 1'b0;
				ld_sat   = sat_q;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			rd_k_s1   <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			rd_k_s1   <= k_q;
			if (state_q == ST_READ) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
		end
	end

	// Latch the query coordinates and face flags
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q     <= coord_x;
			cy_q     <= coord_y;
			cz_q     <= coord_z;
			has_lo_q <= has_lo_in;
			has_hi_q <= has_hi_in;
		end
	end

	ggr_ram #(
		.DEPTH  (VOL_WORDS),
		.WIDTH  (DATA_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (voxel_value),
		.rdata (ram_rdata)
	);

	// Neighbor or centre, per the face flags of the axis in flight
	always_comb begin
		lo_c = centre_q;
		hi_c = centre_q;
		unique case (step_t'(rd_k_s1))
			STEP_X_LO: lo_c = has_lo_q[0] ? ram_rdata : centre_q;
			STEP_Y_LO: lo_c = has_lo_q[1] ? ram_rdata : centre_q;
			STEP_Z_LO: lo_c = has_lo_q[2] ? ram_rdata : centre_q;
			STEP_X_HI: hi_c = has_hi_q[0] ? ram_rdata : centre_q;
			STEP_Y_HI: hi_c = has_hi_q[1] ? ram_rdata : centre_q;
			STEP_Z_HI: hi_c = has_hi_q[2] ? ram_rdata : centre_q;
			default: begin
				lo_c = centre_q;
				hi_c = centre_q;
			end
		endcase
	end

	// Collect read data and form one difference per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
		end else begin
			diff_q.vld <= 1'b0;
			if (rd_vld_s1) begin
				unique case (step_t'(rd_k_s1))
					STEP_CENTRE: centre_q <= ram_rdata;
					STEP_X_LO, STEP_Y_LO, STEP_Z_LO: lo_q <= lo_c;
					STEP_X_HI: begin
						diff_q.vld  <= 1'b1;
						diff_q.axis <= AXIS_X;
						diff_q.half <= has_lo_q[0] && has_hi_q[0];
					end
					STEP_Y_HI: begin
						diff_q.vld  <= 1'b1;
						diff_q.axis <= AXIS_Y;
						diff_q.half <= has_lo_q[1] && has_hi_q[1];
					end
					STEP_Z_HI: begin
						diff_q.vld  <= 1'b1;
						diff_q.axis <= AXIS_Z;
						diff_q.half <= has_lo_q[2] && has_hi_q[2];
					end
					default: diff_q.vld <= 1'b0;
				endcase
				diff_q.diff <= {hi_c[DATA_W-1], hi_c} - {lo_q[DATA_W-1], lo_q};
			end
		end
	end

	ggr_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.inv_spacing (inv_q),
		.diff_i      (diff_q),
		.res_o       (res)
	);

	// Gather the three components and the clip flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (accept) begin
			sat_q <= 1'b0;
		end else if (res.vld) begin
			sat_q <= sat_q || res.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			unique case (res.axis)
				AXIS_X:  gx_q <= res.grad;
				AXIS_Y:  gy_q <= res.grad;
				AXIS_Z:  gz_q <= res.grad;
				default: gz_q <= gz_q;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ogx_q  <= ld_gx;
			ogy_q  <= ld_gy;
			ogz_q  <= ld_gz;
			oq_q   <= ld_q;
			oor_q  <= ld_oor;
			osat_q <= ld_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign grad_x       = ogx_q;
	assign grad_y       = ogy_q;
	assign grad_z       = ogz_q;
	assign is_query     = oq_q;
	assign out_of_range = oor_q;
	assign saturated    = osat_q;

	// RAM writes only happen between queries
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("volume write during a query");

	// The last component only returns while the sequencer waits for it
	a_z_drain: assert property (@(posedge clk) disable iff (!arst_n)
		z_done |-> (state_q == ST_DRAIN))
		else $error("z component outside drain");

	// Never overwrite a stalled result
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while stalled");

	// Read data only follows a read step
	a_rd_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ST_READ))
		else $error("read data without a read");

endmodule

// File: tb/grid_gradient_3d_tb.sv
module grid_gradient_3d_tb
	import ggr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PHASES      = 12;
	// items per phase, fill writes included
	localparam int unsigned PHASE_ITEMS = 110;

	typedef struct {
		logic                     cmd;
		logic [COORD_W-1:0]       x;
		logic [COORD_W-1:0]       y;
		logic [COORD_W-1:0]       z;
		logic signed [DATA_W-1:0] value;
	} vox_item_t;

	typedef struct {
		logic signed [DATA_W-1:0] gx;
		logic signed [DATA_W-1:0] gy;
		logic signed [DATA_W-1:0] gz;
		logic                     query;
		logic                     oor;
		logic                     sat;
	} grad_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      cmd = CMD_WRITE;
	logic [COORD_W-1:0]        coord_x = '0;
	logic [COORD_W-1:0]        coord_y = '0;
	logic [COORD_W-1:0]        coord_z = '0;
	logic signed [DATA_W-1:0]  voxel_value = '0;

	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [DATA_W-1:0]  grad_x;
	logic signed [DATA_W-1:0]  grad_y;
	logic signed [DATA_W-1:0]  grad_z;
	logic                      is_query;
	logic                      out_of_range;
	logic                      saturated;

	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	cfg_reg_t                  cfg_index = REG_SIZE_X;
	logic [DATA_W-1:0]         cfg_data = '0;

	// Shadow of the block: volume contents and register copies
	logic signed [DATA_W-1:0]  shadow_volume [VOL_WORDS];
	bit                        planned [VOL_WORDS];
	logic [SIZE_W-1:0]         size_reg [3] = '{6'd32, 6'd32, 6'd32};
	logic [DATA_W-1:0]         spacing = 32'd65536;

	vox_item_t                 pend_items [$];
	grad_result_t              grad_due [$];

	bit                        in_taken = 1'b0;
	bit                        steady = 1'b0;
	int unsigned               send_gap = 0;
	int unsigned               stall_left = 0;
	int unsigned               free_left = 0;
	int unsigned               mismatches = 0;
	int unsigned               cycle_count = 0;
	int unsigned               queued = 0;

	grid_gradient_3d dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.voxel_value  (voxel_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z),
		.is_query     (is_query),
		.out_of_range (out_of_range),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Size register as seen by the datapath: anything above the grid max counts as the max
	function automatic int unsigned used_cells(logic [SIZE_W-1:0] r, int unsigned m);
		return (int'(r) > int'(m)) ? m : int'(r);
	endfunction

	function automatic int unsigned vox_index(int unsigned x, int unsigned y, int unsigned z);
		return (z * MAX_Y + y) * MAX_X + x;
	endfunction

	function automatic bit in_range(int unsigned x, int unsigned y, int unsigned z);
		return x < used_cells(size_reg[0], MAX_X) && y < used_cells(size_reg[1], MAX_Y)
			&& z < used_cells(size_reg[2], MAX_Z);
	endfunction

	function automatic longint voxel_at(int unsigned x, int unsigned y, int unsigned z);
		return longint'(shadow_volume[vox_index(x, y, z)]);
	endfunction

	// diff * spacing, halved unless one-sided, rounded half away from zero, clipped
	function automatic logic signed [DATA_W-1:0] scaled_slope(longint diff, bit whole,
	                                                         output bit clip);
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] rnd;
		int unsigned sh;
		clip = 1'b0;
		sh = whole ? 16 : 17;
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = mag * 64'(spacing);
		rnd = (prod >> sh) + ((prod >> (sh - 1)) & 64'd1);
		if (diff >= 0) begin
			if (rnd > 64'h7FFF_FFFF) begin
				clip = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return DATA_W'(rnd);
		end
		if (rnd > 64'h8000_0000) begin
			clip = 1'b1;
			return 32'h8000_0000;
		end
		return DATA_W'(-rnd);
	endfunction

	function automatic grad_result_t predict_gradient(vox_item_t it);
		grad_result_t r;
		int unsigned n [3];
		int unsigned c [3];
		int unsigned p [3];
		logic signed [DATA_W-1:0] g [3];
		longint centre;
		longint lo;
		longint hi;
		bit whole;
		bit clip;
		r.query = (it.cmd == CMD_QUERY);
		r.oor = !in_range(32'(it.x), 32'(it.y), 32'(it.z));
		r.sat = 1'b0;
		g = '{default: '0};
		if (r.query && !r.oor) begin
			n = '{used_cells(size_reg[0], MAX_X), used_cells(size_reg[1], MAX_Y),
				used_cells(size_reg[2], MAX_Z)};
			c = '{32'(it.x), 32'(it.y), 32'(it.z)};
			centre = voxel_at(c[0], c[1], c[2]);
			for (int a = 0; a < 3; a++) begin
				lo = centre;
				hi = centre;
				whole = 1'b0;
				// missing neighbor at a face: centre stands in, no halving
				if (c[a] != 0) begin
					p = c;
					p[a] = c[a] - 1;
					lo = voxel_at(p[0], p[1], p[2]);
				end else begin
					whole = 1'b1;
				end
				if (c[a] + 1 < n[a]) begin
					p = c;
					p[a] = c[a] + 1;
					hi = voxel_at(p[0], p[1], p[2]);
				end else begin
					whole = 1'b1;
				end
				g[a] = scaled_slope(hi - lo, whole, clip);
				r.sat = r.sat | clip;
			end
		end
		r.gx = g[0];
		r.gy = g[1];
		r.gz = g[2];
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return SIZE_W'($urandom_range(33, 63));
		end
		if (r < 7) begin
			return 6'd32;
		end
		if (r < 9) begin
			return 6'd1;
		end
		return SIZE_W'($urandom_range(2, 8));
	endfunction

	function automatic logic [DATA_W-1:0] rand_spacing();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			3: return 32'd65536;
			4: return $urandom;
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	function automatic int unsigned pick_coord(int unsigned n, bit bounded);
		if (bounded && n > 0) begin
			return $urandom_range(0, n - 1);
		end
		return $urandom_range(0, 31);
	endfunction

	task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
	                               logic [DATA_W-1:0] want);
		$display("mismatch on %s: got %h, want %h (cycle %0d)", field, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic queue_write(int unsigned x, int unsigned y, int unsigned z,
	                           logic signed [DATA_W-1:0] v);
		pend_items = {pend_items,
			vox_item_t'{CMD_WRITE, COORD_W'(x), COORD_W'(y), COORD_W'(z), v}};
		queued++;
		if (in_range(x, y, z)) begin
			planned[vox_index(x, y, z)] = 1'b1;
		end
	endtask

	task automatic fill_voxel(int unsigned x, int unsigned y, int unsigned z);
		if (!planned[vox_index(x, y, z)]) begin
			queue_write(x, y, z, rand_value());
		end
	endtask

	// A query in range is preceded by writes of any voxel it reads that is still empty
	task automatic queue_query(int unsigned x, int unsigned y, int unsigned z);
		int unsigned nx;
		int unsigned ny;
		int unsigned nz;
		nx = used_cells(size_reg[0], MAX_X);
		ny = used_cells(size_reg[1], MAX_Y);
		nz = used_cells(size_reg[2], MAX_Z);
		if (in_range(x, y, z)) begin
			fill_voxel(x, y, z);
			if (x > 0) fill_voxel(x - 1, y, z);
			if (x + 1 < nx) fill_voxel(x + 1, y, z);
			if (y > 0) fill_voxel(x, y - 1, z);
			if (y + 1 < ny) fill_voxel(x, y + 1, z);
			if (z > 0) fill_voxel(x, y, z - 1);
			if (z + 1 < nz) fill_voxel(x, y, z + 1);
		end
		pend_items = {pend_items,
			vox_item_t'{CMD_QUERY, COORD_W'(x), COORD_W'(y), COORD_W'(z), DATA_W'($urandom)}};
		queued++;
	endtask

	// Hold the sender until every pending result is back, then let the pipe go quiet
	task automatic settle();
		while (pend_items.size() != 0 || grad_due.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SIZE_X: size_reg[0] = data[SIZE_W-1:0];
			REG_SIZE_Y: size_reg[1] = data[SIZE_W-1:0];
			REG_SIZE_Z: size_reg[2] = data[SIZE_W-1:0];
			REG_INV_SPACING: spacing = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Size writes carry junk above the 6-bit field
	task automatic configure(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
	                         logic [SIZE_W-1:0] sz, logic [DATA_W-1:0] inv);
		settle();
		write_register(REG_SIZE_X, {26'($urandom), sx});
		write_register(REG_SIZE_Y, {26'($urandom), sy});
		write_register(REG_SIZE_Z, {26'($urandom), sz});
		write_register(REG_INV_SPACING, inv);
	endtask

	// Sender: next item from the queue once the current one is taken
	always @(negedge clk) begin
		vox_item_t it;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pend_items.size() > 0) begin
				it = pend_items.pop_front();
				cmd <= it.cmd;
				coord_x <= it.x;
				coord_y <= it.y;
				coord_z <= it.z;
				voxel_value <= it.value;
				in_valid <= 1'b1;
				send_gap = idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: stall bursts between free runs
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (free_left > 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = idle_len();
			free_left = $urandom_range(1, 8);
		end
	end

	// Check accepted results, predict accepted items
	always @(posedge clk) begin
		grad_result_t want;
		vox_item_t it;
		in_taken = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (grad_due.size() == 0) begin
					report_mismatch("unexpected result", grad_x, '0);
				end else begin
					want = grad_due.pop_front();
					if (grad_x !== want.gx) report_mismatch("grad_x", grad_x, want.gx);
					if (grad_y !== want.gy) report_mismatch("grad_y", grad_y, want.gy);
					if (grad_z !== want.gz) report_mismatch("grad_z", grad_z, want.gz);
					if (is_query !== want.query) begin
						report_mismatch("is_query", DATA_W'(is_query), DATA_W'(want.query));
					end
					if (out_of_range !== want.oor) begin
						report_mismatch("out_of_range", DATA_W'(out_of_range),
							DATA_W'(want.oor));
					end
					if (saturated !== want.sat) begin
						report_mismatch("saturated", DATA_W'(saturated), DATA_W'(want.sat));
					end
				end
			end
			if (in_valid && !in_stall) begin
				it = vox_item_t'{cmd, coord_x, coord_y, coord_z, voxel_value};
				grad_due = {grad_due, predict_gradient(it)};
				if (it.cmd == CMD_WRITE && in_range(32'(it.x), 32'(it.y), 32'(it.z))) begin
					shadow_volume[vox_index(32'(it.x), 32'(it.y), 32'(it.z))] = it.value;
				end
				in_taken = 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned nx;
		int unsigned ny;
		int unsigned nz;
		int unsigned k;
		int unsigned phase_start;
		bit bounded;
		bit mid_done;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset geometry: corner with opposite extremes saturates the x and y axes
		queue_write(0, 0, 0, 32'h7FFF_FFFF);
		queue_write(1, 0, 0, 32'h8000_0000);
		queue_write(0, 1, 0, 32'h8000_0000);
		queue_write(0, 0, 1, 32'h0000_0000);
		queue_query(0, 0, 0);
		// far corner, then an interior point with halved differences
		queue_query(31, 31, 31);
		queue_query(5, 6, 7);

		// Single-cell grid, maximum spacing: zero gradients, out-of-range items
		configure(6'd1, 6'd1, 6'd1, 32'hFFFF_FFFF);
		queue_query(0, 0, 0);
		queue_query(1, 0, 0);
		queue_write(3, 2, 1, 32'h1234_5678);
		queue_query(0, 0, 31);

		// Zero x size, y above max, zero spacing
		configure(6'd0, 6'd63, 6'd2, 32'd0);
		queue_query(0, 0, 0);
		queue_write(0, 1, 1, 32'h7FFF_FFFF);
		configure(6'd32, 6'd63, 6'd2, 32'd0);
		queue_query(0, 1, 1);
		queue_query(0, 31, 1);

		// Random phases, each with its own geometry and spacing
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				configure(6'd32, 6'd32, 6'd32, rand_spacing());
			end else begin
				configure(rand_size(), rand_size(), rand_size(), rand_spacing());
			end
			steady = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
			nx = used_cells(size_reg[0], MAX_X);
			ny = used_cells(size_reg[1], MAX_Y);
			nz = used_cells(size_reg[2], MAX_Z);
			phase_start = queued;
			mid_done = 1'b0;
			while (queued - phase_start < PHASE_ITEMS) begin
				if (!mid_done && queued - phase_start >= PHASE_ITEMS / 2) begin
					settle();
					mid_done = 1'b1;
				end
				k = $urandom_range(0, 99);
				bounded = (k < 75);
				if (k < 45 || k >= 85) begin
					queue_query(pick_coord(nx, bounded), pick_coord(ny, bounded),
						pick_coord(nz, bounded));
				end else begin
					queue_write(pick_coord(nx, bounded), pick_coord(ny, bounded),
						pick_coord(nz, bounded), rand_value());
				end
			end
		end

		settle();
		repeat (30) @(posedge clk);
		if (grad_due.size() != 0) begin
			report_mismatch("results outstanding", DATA_W'(grad_due.size()), '0);
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
